// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the angle frame parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IAFP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IAFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/iafp_pkg.sv =====
// ----------------------------------------------------------------------------
// iafp_pkg
// Types and constants shared by the angle frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iafp_pkg;

   localparam int PKT_BYTES   = 11;
   // Bytes held between items; the eleventh byte is always the incoming one.
   localparam int WIN_HELD    = PKT_BYTES - 1;
   localparam int FILL_W      = 4;

   localparam logic [7:0] FRAME_HEADER     = 8'h55;
   localparam logic [7:0] FRAME_TYPE_ANGLE = 8'h53;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_ZERO = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_FRAME_OK  = 3'd1,
      ST_ZERO_OK   = 3'd2,
      ST_ZERO_WAIT = 3'd3,
      ST_READ_OK   = 3'd4,
      ST_NO_DATA   = 3'd5
   } status_type;

   typedef struct packed {
      logic header_ok;
      logic type_ok;
      logic sum_ok;
   } frame_chk_type;

endpackage

`default_nettype wire

// ===== hdl/iafp_frame_chk.sv =====
// ----------------------------------------------------------------------------
// iafp_frame_chk
// Header, type and checksum test of a full window (held bytes plus new byte).
// ----------------------------------------------------------------------------
`default_nettype none

module iafp_frame_chk (
   input  logic [7:0]              win [iafp_pkg::WIN_HELD],
   input  logic [7:0]              new_byte,
   output iafp_pkg::frame_chk_type chk
);
   import iafp_pkg::*;

   localparam int PAIRS = WIN_HELD / 2;

   logic [7:0] pair_sum [PAIRS];
   logic [7:0] total;

   // pair sums in parallel, then a short chain over the pairs
   always_comb begin
      for (int i = 0; i < PAIRS; i++) begin
         pair_sum[i] = win[2*i] + win[2*i+1];
      end
      total = 8'd0;
      for (int i = 0; i < PAIRS; i++) begin
         total = total + pair_sum[i];
      end
   end

   assign chk.header_ok = (win[0] == FRAME_HEADER);
   assign chk.type_ok   = (win[1] == FRAME_TYPE_ANGLE);
   assign chk.sum_ok    = (total == new_byte);

endmodule

`default_nettype wire

// ===== hdl/imu_angle_frame_parser_with_yaw_zero.sv =====
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_with_yaw_zero
// 11-byte angle frame parser for a serial IMU stream, with software yaw zero.
// ----------------------------------------------------------------------------
// Result path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled; the whole frame test
//    and state update fit in the single stage between the input and result registers.
// Reset: synchronous, active high; clears valids, fill count, angles, zero
//    state and counters. Window bytes are not reset (read only below fill).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module imu_angle_frame_parser_with_yaw_zero (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_rx_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic [31:0]        rsp_zero_count,
   output logic [31:0]        rsp_frames_seen
);
   import iafp_pkg::*;

   // ---------------- input stage ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_opcode_ff;
   logic [7:0] s1_byte_ff;

   // ---------------- parser state ----------------
   logic [7:0]        win_ff [WIN_HELD];
   logic [7:0]        win_in [WIN_HELD];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       pitch_ff, pitch_in;
   logic [15:0]       roll_ff, roll_in;
   logic [15:0]       raw_yaw_ff, raw_yaw_in;
   logic [15:0]       head_ref_ff, head_ref_in;
   logic [15:0]       rel_yaw_ff, rel_yaw_in;
   logic              zero_known_ff, zero_known_in;
   logic [31:0]       zero_count_ff, zero_count_in;
   logic [31:0]       frame_total_ff, frame_total_in;
   logic              fresh_ff, fresh_in;

   // ---------------- result stage ----------------
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_in, rsp_status_ff;
   logic [15:0]       rsp_pitch_ff, rsp_roll_ff, rsp_yaw_ff;
   logic [31:0]       rsp_zgen_ff, rsp_frames_ff;
   logic              show;

   // ---------------- handshake ----------------
   logic out_free;    // result register can take a new item this cycle
   logic load;        // input stage item is processed this cycle
   logic req_accept;

   frame_chk_type chk;
   logic          win_full;   // incoming byte completes an 11-byte window
   logic [15:0]   win_raw_yaw;
   logic [15:0]   zero_sel;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      load       = s1_valid_ff && out_free;
      req_stall  = s1_valid_ff && !out_free;
      req_accept = req_valid && !req_stall;
      s1_valid_in  = req_accept || (s1_valid_ff && !load);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   iafp_frame_chk u_chk (
      .win      (win_ff),
      .new_byte (s1_byte_ff),
      .chk      (chk)
   );

   assign win_full    = (fill_ff == FILL_W'(WIN_HELD));
   assign win_raw_yaw = {win_ff[7], win_ff[6]};
   // first frame ever (or after a deferred zero) becomes its own zero
   assign zero_sel    = zero_known_ff ? head_ref_ff : win_raw_yaw;

   // ---------------- next-state logic ----------------
   always_comb begin
      win_in         = win_ff;
      fill_in        = fill_ff;
      pitch_in       = pitch_ff;
      roll_in        = roll_ff;
      raw_yaw_in     = raw_yaw_ff;
      head_ref_in    = head_ref_ff;
      rel_yaw_in     = rel_yaw_ff;
      zero_known_in  = zero_known_ff;
      zero_count_in  = zero_count_ff;
      frame_total_in = frame_total_ff;
      fresh_in       = fresh_ff;
      status_in      = ST_NONE;
      show           = 1'b0;

      if (load) begin
         unique case (opcode_type'(s1_opcode_ff))
            OP_BYTE: begin
               if (!win_full) begin
                  // still filling: store at fill position
                  for (int k = 0; k < WIN_HELD; k++) begin
                     if (fill_ff == FILL_W'(k)) begin
                        win_in[k] = s1_byte_ff;
                     end
                  end
                  fill_in = fill_ff + FILL_W'(1);
               end else if (!chk.header_ok || (chk.type_ok && !chk.sum_ok)) begin
                  // slide by one byte, window stays ten deep
                  for (int k = 0; k < WIN_HELD - 1; k++) begin
                     win_in[k] = win_ff[k+1];
                  end
                  win_in[WIN_HELD-1] = s1_byte_ff;
                  fill_in = FILL_W'(WIN_HELD);
               end else if (!chk.type_ok) begin
                  fill_in = '0;        // wrong type: drop whole window
               end else begin
                  // good angle frame
                  pitch_in   = {win_ff[3], win_ff[2]};
                  roll_in    = {win_ff[5], win_ff[4]};
                  raw_yaw_in = win_raw_yaw;
                  if (!zero_known_ff) begin
                     head_ref_in   = win_raw_yaw;
                     zero_known_in = 1'b1;
                     zero_count_in = zero_count_ff + 32'd1;
                  end
                  rel_yaw_in     = win_raw_yaw - zero_sel;
                  frame_total_in = frame_total_ff + 32'd1;
                  fresh_in       = 1'b1;
                  fill_in        = '0;
                  status_in      = ST_FRAME_OK;
                  show           = 1'b1;
               end
            end
            OP_ZERO: begin
               if (frame_total_ff != 32'd0) begin
                  head_ref_in   = raw_yaw_ff;
                  zero_known_in = 1'b1;
                  zero_count_in = zero_count_ff + 32'd1;
                  rel_yaw_in    = '0;
                  fresh_in      = 1'b1;
                  status_in     = ST_ZERO_OK;
                  show          = 1'b1;
               end else begin
                  // no frame yet: next good frame sets the zero
                  zero_known_in = 1'b0;
                  status_in     = ST_ZERO_WAIT;
               end
            end
            OP_READ: begin
               if (fresh_ff) begin
                  fresh_in  = 1'b0;
                  status_in = ST_READ_OK;
                  show      = 1'b1;
               end else begin
                  status_in = ST_NO_DATA;
               end
            end
            default: begin
               status_in = ST_NONE;   // unused opcode: no effect
            end
         endcase
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fill_ff        <= '0;
         pitch_ff       <= '0;
         roll_ff        <= '0;
         raw_yaw_ff     <= '0;
         head_ref_ff    <= '0;
         rel_yaw_ff     <= '0;
         zero_known_ff  <= 1'b0;
         zero_count_ff  <= '0;
         frame_total_ff <= '0;
         fresh_ff       <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         fill_ff        <= fill_in;
         pitch_ff       <= pitch_in;
         roll_ff        <= roll_in;
         raw_yaw_ff     <= raw_yaw_in;
         head_ref_ff    <= head_ref_in;
         rel_yaw_ff     <= rel_yaw_in;
         zero_known_ff  <= zero_known_in;
         zero_count_ff  <= zero_count_in;
         frame_total_ff <= frame_total_in;
         fresh_ff       <= fresh_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff <= req_opcode;
         s1_byte_ff   <= req_rx_byte;
      end
      win_ff <= win_in;
      if (load) begin
         rsp_status_ff <= status_in;
         rsp_pitch_ff  <= show ? pitch_in   : 16'd0;
         rsp_roll_ff   <= show ? roll_in    : 16'd0;
         rsp_yaw_ff    <= show ? rel_yaw_in : 16'd0;
         rsp_zgen_ff   <= zero_count_in;
         rsp_frames_ff <= frame_total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_pitch_angle     = $signed(rsp_pitch_ff);
   assign rsp_roll_angle      = $signed(rsp_roll_ff);
   assign rsp_yaw_angle       = $signed(rsp_yaw_ff);
   assign rsp_zero_count      = rsp_zgen_ff;
   assign rsp_frames_seen     = rsp_frames_ff;

   // ---------------- assertions ----------------
   `IAFP_ASSERT_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= FILL_W'(WIN_HELD),
      "window fill count out of range")
   `IAFP_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff,
      "request stalled without a pending item")
   `IAFP_ASSERT_NEXT(a_frame_clears_win, clock, reset, load && status_in == ST_FRAME_OK,
      fill_ff == '0 && fresh_ff && zero_known_ff, "accepted frame left window or flags stale")
   `IAFP_ASSERT_NEXT(a_zero_sets_known, clock, reset, load && status_in == ST_ZERO_OK,
      zero_known_ff && rel_yaw_ff == 16'd0, "applied zero did not take effect")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU angle frame parser with software yaw zero.
// Drives bytes, zero and read commands over the req_ channel, predicts every
// result in a scoreboard and checks each rsp_ item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   import iafp_pkg::*;

   // Opcode 3 is unused by the block: no state change, status ST_NONE.
   localparam logic [1:0] OP_SPARE = 2'd3;
   // Receiver hold-off long enough to back the block up into req_stall.
   localparam int HOLD_CYCLES = 100;
   localparam int MAX_REPORTS = 10;

   // One predicted result item.
   typedef struct {
      status_type  status;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] yaw;
      logic [31:0] zero_gen;
      logic [31:0] frames;
   } angle_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the parser state, predicted results in order.
   // -------------------------------------------------------------------------
   class angle_frame_scoreboard;
      angle_result_type pending_angles[$];
      logic [7:0]       window [PKT_BYTES];
      int               fill;
      logic [15:0]      pitch, roll, raw_yaw, head_ref, rel_yaw;
      bit               zero_known, fresh;
      logic [31:0]      zero_count, frame_total;
      int               errors, checked;
      int               status_hits [6];

      function new();
         foreach (window[k]) window[k] = '0;
         fill = 0;
         pitch = '0; roll = '0; raw_yaw = '0; head_ref = '0; rel_yaw = '0;
         zero_known = 0; fresh = 0;
         zero_count = '0; frame_total = '0;
         errors = 0; checked = 0;
         foreach (status_hits[k]) status_hits[k] = 0;
      endfunction

      // Update the state for one accepted item and queue its result.
      function void note_accepted_item(logic [1:0] op, logic [7:0] b);
         angle_result_type r;
         logic [7:0]       sum;
         bit               show;
         int               k;
         show = 0;
         sum = '0;
         r.status = ST_NONE;
         case (op)
            OP_BYTE: begin
               if (fill >= PKT_BYTES) fill = 0;
               window[fill] = b;
               fill++;
               if (fill == PKT_BYTES) begin
                  for (k = 0; k < WIN_HELD; k++) sum += window[k];
                  if (window[0] != FRAME_HEADER ||
                      (window[1] == FRAME_TYPE_ANGLE && sum != window[WIN_HELD])) begin
                     // bad header or bad sum: slide by one byte
                     for (k = 0; k < WIN_HELD; k++) window[k] = window[k + 1];
                     fill = WIN_HELD;
                  end else if (window[1] != FRAME_TYPE_ANGLE) begin
                     fill = 0;
                  end else begin
                     pitch   = {window[3], window[2]};
                     roll    = {window[5], window[4]};
                     raw_yaw = {window[7], window[6]};
                     if (!zero_known) begin
                        head_ref   = raw_yaw;
                        zero_known = 1;
                        zero_count++;
                     end
                     rel_yaw = raw_yaw - head_ref;
                     frame_total++;
                     fresh    = 1;
                     fill     = 0;
                     r.status = ST_FRAME_OK;
                     show     = 1;
                  end
               end
            end
            OP_ZERO: begin
               if (frame_total != 0) begin
                  head_ref   = raw_yaw;
                  zero_known = 1;
                  zero_count++;
                  rel_yaw    = '0;
                  fresh      = 1;
                  r.status   = ST_ZERO_OK;
                  show       = 1;
               end else begin
                  // no frame yet: the next good frame becomes the zero
                  zero_known = 0;
                  r.status   = ST_ZERO_WAIT;
               end
            end
            OP_READ: begin
               if (fresh) begin
                  fresh    = 0;
                  r.status = ST_READ_OK;
                  show     = 1;
               end else begin
                  r.status = ST_NO_DATA;
               end
            end
            default: ;
         endcase
         r.pitch    = show ? pitch   : '0;
         r.roll     = show ? roll    : '0;
         r.yaw      = show ? rel_yaw : '0;
         r.zero_gen = zero_count;
         r.frames   = frame_total;
         pending_angles.push_back(r);
      endfunction

      function void flag_field(string name, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("ERROR result %0d %s: expected 0x%0h, got 0x%0h",
                     checked, name, want, got);
      endfunction

      function void check_result(logic [2:0] status, logic [15:0] p, logic [15:0] r,
                                 logic [15:0] y, logic [31:0] zg, logic [31:0] fs);
         angle_result_type want;
         if (pending_angles.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR result with nothing outstanding: status %0d", status);
            return;
         end
         want = pending_angles.pop_front();
         status_hits[want.status]++;
         if (status !== want.status)
            flag_field("status", 32'(want.status), 32'(status));
         if (p      !== want.pitch)     flag_field("pitch", 32'(want.pitch), 32'(p));
         if (r      !== want.roll)      flag_field("roll", 32'(want.roll), 32'(r));
         if (y      !== want.yaw)       flag_field("yaw", 32'(want.yaw), 32'(y));
         if (zg     !== want.zero_gen)  flag_field("zero count", want.zero_gen, zg);
         if (fs     !== want.frames)    flag_field("frames_seen", want.frames, fs);
         checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_status;
   logic signed [15:0] rsp_pitch_angle;
   logic signed [15:0] rsp_roll_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic [31:0]        rsp_zero_count;
   logic [31:0]        rsp_frames_seen;

   imu_angle_frame_parser_with_yaw_zero i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_pitch_angle     (rsp_pitch_angle),
      .rsp_roll_angle      (rsp_roll_angle),
      .rsp_yaw_angle       (rsp_yaw_angle),
      .rsp_zero_count      (rsp_zero_count),
      .rsp_frames_seen     (rsp_frames_seen)
   );

   angle_frame_scoreboard sb;
   int send_idle_pct;   // chance per cycle that the sender holds valid low
   int recv_idle_pct;   // chance per cycle that the receiver raises stall
   int hold_ask;        // bumped by the stimulus to request a long hold-off
   int items_sent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #800_000;
      $display("TIMEOUT: %0d results still outstanding", sb.pending_angles.size());
      $display("imu_angle_frame_parser_with_yaw_zero: mismatch");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall, plus a long hold-off counted here on request.
   // -------------------------------------------------------------------------
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Result monitor. Outputs and our inputs only move right after the rising
   // edge, so the falling edge shows exactly what the next edge will take.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_pitch_angle, rsp_roll_angle, rsp_yaw_angle,
                         rsp_zero_count, rsp_frames_seen);
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Offer one item, holding it until the block takes it.
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall);
      sb.note_accepted_item(op, b);
      @(posedge clock);
      items_sent++;
   endtask

   // Eleven-byte angle frame; corrupt flips one bit of the checksum.
   task automatic send_frame(input logic [15:0] p, input logic [15:0] r,
                             input logic [15:0] y, input logic [7:0] kind,
                             input bit corrupt);
      logic [7:0] bytes [PKT_BYTES];
      logic [7:0] sum;
      int         k;
      bytes[0] = FRAME_HEADER;
      bytes[1] = kind;
      bytes[2] = p[7:0];
      bytes[3] = p[15:8];
      bytes[4] = r[7:0];
      bytes[5] = r[15:8];
      bytes[6] = y[7:0];
      bytes[7] = y[15:8];
      bytes[8] = 8'($urandom);
      bytes[9] = 8'($urandom);
      sum = '0;
      for (k = 0; k < WIN_HELD; k++) sum += bytes[k];
      bytes[WIN_HELD] = corrupt ? sum ^ (8'd1 << $urandom_range(7)) : sum;
      for (k = 0; k < PKT_BYTES; k++) send_item(OP_BYTE, bytes[k]);
   endtask

   // Angle value, weighted toward the 16-bit extremes.
   function automatic logic [15:0] pick_angle();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sender pause: valid low until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_angles.size() != 0) @(posedge clock);
   endtask

   // Random traffic: mostly good frames with random content, mixed with
   // broken frames, stray bytes and zero/read commands.
   task automatic run_phase(input int upto, input int s_pct, input int r_pct,
                            input bit long_hold);
      logic [7:0] t;
      int         n;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      if (long_hold) hold_ask++;
      while (items_sent < upto) begin
         n = $urandom_range(99);
         if (n < 60) begin
            send_frame(pick_angle(), pick_angle(), pick_angle(), FRAME_TYPE_ANGLE, 0);
         end else if (n < 70) begin
            send_frame(pick_angle(), pick_angle(), pick_angle(), FRAME_TYPE_ANGLE, 1);
         end else if (n < 75) begin
            t = 8'($urandom);
            if (t == FRAME_TYPE_ANGLE) t = ~t;
            send_frame(pick_angle(), pick_angle(), pick_angle(), t, 0);
         end else if (n < 82) begin
            // stray bytes, sometimes a lone header
            repeat ($urandom_range(1, 4))
               send_item(OP_BYTE, $urandom_range(3) == 0 ? FRAME_HEADER : 8'($urandom));
         end else if (n < 88) begin
            send_item(OP_ZERO, 8'($urandom));
         end else if (n < 97) begin
            send_item(OP_READ, 8'($urandom));
         end else begin
            send_item(OP_SPARE, 8'($urandom));
         end
      end
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_BYTE;
      req_rx_byte   = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_ask      = 0;
      items_sent    = 0;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty read, zero before any frame (deferred), unused op,
      // a stray byte ahead of an extreme-valued frame (slides once, then the
      // frame lands and takes the deferred zero), reads with and without
      // fresh data, a zero at the current heading, and a read after it.
      send_item(OP_READ, 8'hFF);
      send_item(OP_ZERO, 8'h00);
      send_item(OP_SPARE, 8'hA5);
      send_item(OP_BYTE, 8'h00);
      send_frame(16'h8000, 16'h7FFF, 16'hFFFF, FRAME_TYPE_ANGLE, 0);
      send_item(OP_READ, 8'h00);
      send_item(OP_READ, 8'h00);
      send_item(OP_ZERO, 8'hFF);
      send_item(OP_READ, 8'h5A);
      drain();

      // Sender light, receiver heavy, with one long receiver hold-off.
      run_phase(items_sent + 410, 29, 59, 1);
      // Roles swapped.
      run_phase(items_sent + 410, 59, 29, 0);
      // Full rate both sides, long hold-off while items keep coming.
      run_phase(items_sent + 410, 0, 0, 1);

      // Tail: wait out any stray results.
      repeat (8) @(posedge clock);

      $display("Ran %0d items: %0d frames accepted, %0d yaw zeros, %0d results checked.",
               items_sent, sb.frame_total, sb.zero_count, sb.checked);
      $display("Status mix: none %0d, frame %0d, zero %0d, deferred %0d, read %0d, stale %0d",
               sb.status_hits[ST_NONE], sb.status_hits[ST_FRAME_OK],
               sb.status_hits[ST_ZERO_OK], sb.status_hits[ST_ZERO_WAIT],
               sb.status_hits[ST_READ_OK], sb.status_hits[ST_NO_DATA]);
      if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
         $display("imu_angle_frame_parser_with_yaw_zero: match");
      end else begin
         $display("%0d field errors", sb.errors);
         $display("imu_angle_frame_parser_with_yaw_zero: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
